>>> src/hcbp_pkg.sv
`default_nettype none

package hcbp_pkg;

  localparam int WORD_W           = 32;  // width of code_word and of the bit total
  localparam int SYM_W            = 8;
  localparam int TABLE_DEPTH      = 256;
  localparam int BYTE_BITS        = 8;
  localparam int NBITS_W          = 4;
  localparam int LEN_IN_W         = 6;
  localparam int PEND_W           = 7;   // at most 7 bits wait for a byte to complete
  localparam int PCNT_W           = 3;
  localparam int MAX_CODE_LEN_DEF = 32;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_ENCODE = 2'd1;
  localparam logic [1:0] MODE_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]          mode;
    logic [SYM_W-1:0]    symbol;
    logic [WORD_W-1:0]   code_word;
    logic [LEN_IN_W-1:0] code_length;
  } req_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] packed_byte;
    logic [NBITS_W-1:0]   bits_in_byte;
    logic [WORD_W-1:0]    total_bits;
    logic                 last;
  } rsp_t;

  // Handoff of one group of result bytes from the packer to the output stage.
  typedef struct packed {
    logic load;
    logic flush;
  } grp_ctl_t;

endpackage

`default_nettype wire

>>> src/hcbp_code_table.sv
`default_nettype none

module hcbp_code_table import hcbp_pkg::*; #(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
  localparam int CODE_W = (MAX_CODE_LEN > WORD_W) ? WORD_W : MAX_CODE_LEN,
  localparam int LEN_W  = $clog2(CODE_W + 1)
) (
  input  logic              clk,
  input  logic              take,
  input  req_t              req,
  output logic [CODE_W-1:0] rd_word,
  output logic [LEN_W-1:0]  rd_len
);

  localparam int ENT_W = CODE_W + LEN_W;

  logic [ENT_W-1:0]  mem [TABLE_DEPTH];
  logic [LEN_W-1:0]  len_sat;
  logic [CODE_W-1:0] word_m;

  // saturate length, drop word bits above it
  always_comb begin
    if (req.code_length > LEN_IN_W'(CODE_W)) begin
      len_sat = LEN_W'(CODE_W);
    end else begin
      len_sat = req.code_length[LEN_W-1:0];
    end
    for (int i = 0; i < CODE_W; i++) begin
      word_m[i] = req.code_word[i] & (LEN_W'(i) < len_sat);
    end
  end

  always_ff @(posedge clk) begin
    if (take && (req.mode == MODE_LOAD)) begin
      mem[req.symbol] <= {len_sat, word_m};
    end
    if (take) begin
      {rd_len, rd_word} <= mem[req.symbol];
    end
  end

endmodule

`default_nettype wire

>>> src/hcbp_packer.sv
`default_nettype none

module hcbp_packer import hcbp_pkg::*; #(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
  localparam int CODE_W    = (MAX_CODE_LEN > WORD_W) ? WORD_W : MAX_CODE_LEN,
  localparam int LEN_W     = $clog2(CODE_W + 1),
  localparam int ACC_W     = CODE_W + PEND_W,
  localparam int MAX_BYTES = ACC_W / BYTE_BITS,
  localparam int NB_W      = $clog2(MAX_BYTES + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                take,
  input  logic [1:0]                          req_mode,
  input  logic [CODE_W-1:0]                   rd_word,
  input  logic [LEN_W-1:0]                    rd_len,
  input  logic                                grp_free,
  output logic                                stall,
  output grp_ctl_t                            grp_ctl,
  output logic [MAX_BYTES-1:0][BYTE_BITS-1:0] grp_bytes,
  output logic [NB_W-1:0]                     grp_nbytes,
  output logic [NBITS_W-1:0]                  grp_nbits,
  output logic [WORD_W-1:0]                   grp_total
);

  localparam int CNT_W = $clog2(ACC_W + 1);

  logic              s1_valid;
  logic [1:0]        s1_mode;
  logic [PEND_W-1:0] pend_bits;
  logic [PCNT_W-1:0] pend_cnt;
  logic [WORD_W-1:0] bit_total;

  logic [ACC_W-1:0]          acc;
  logic [ACC_W-1:0]          aligned;
  logic [CNT_W-1:0]          count;
  logic [PEND_W-1:0]         pend_mask;
  logic [2*BYTE_BITS-2:0]    flush_tmp;
  logic                      is_flush;
  logic                      has_out;
  logic                      s1_move;

  always_comb begin
    acc     = (ACC_W'(pend_bits) << rd_len) | ACC_W'(rd_word);
    count   = CNT_W'(pend_cnt) + CNT_W'(rd_len);
    // first code bit to the top of the word
    aligned = acc << (CNT_W'(ACC_W) - count);
    pend_mask = PEND_W'((8'd1 << count[PCNT_W-1:0]) - 8'd1);
    flush_tmp = (2*BYTE_BITS-1)'(pend_bits) << (NBITS_W'(BYTE_BITS) - NBITS_W'(pend_cnt));

    is_flush = (s1_mode == MODE_FLUSH);
    has_out  = is_flush || ((s1_mode == MODE_ENCODE) && (count >= CNT_W'(BYTE_BITS)));
    s1_move  = s1_valid && (!has_out || grp_free);
    stall    = s1_valid && !s1_move;

    for (int k = 0; k < MAX_BYTES; k++) begin
      grp_bytes[k] = aligned[ACC_W-1-BYTE_BITS*k -: BYTE_BITS];
    end
    grp_nbytes = NB_W'(count >> 3);
    if (is_flush) begin
      grp_bytes[0] = flush_tmp[BYTE_BITS-1:0];
      grp_nbytes   = NB_W'(1);
    end

    grp_ctl.load  = s1_valid && has_out && grp_free;
    grp_ctl.flush = is_flush;
    grp_nbits     = NBITS_W'(pend_cnt);
    grp_total     = bit_total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      pend_bits <= '0;
      pend_cnt  <= '0;
      bit_total <= '0;
    end else begin
      if (!stall) begin
        s1_valid <= take;
      end
      if (s1_move) begin
        case (s1_mode)
          MODE_ENCODE: begin
            pend_cnt  <= count[PCNT_W-1:0];
            pend_bits <= acc[PEND_W-1:0] & pend_mask;
            bit_total <= bit_total + WORD_W'(rd_len);
          end
          MODE_FLUSH: begin
            pend_cnt  <= '0;
            pend_bits <= '0;
            bit_total <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_mode <= req_mode;
    end
  end

endmodule

`default_nettype wire

>>> src/hcbp_out_stage.sv
`default_nettype none

module hcbp_out_stage import hcbp_pkg::*; #(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
  localparam int CODE_W    = (MAX_CODE_LEN > WORD_W) ? WORD_W : MAX_CODE_LEN,
  localparam int ACC_W     = CODE_W + PEND_W,
  localparam int MAX_BYTES = ACC_W / BYTE_BITS,
  localparam int NB_W      = $clog2(MAX_BYTES + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  grp_ctl_t                            grp_ctl,
  input  logic [MAX_BYTES-1:0][BYTE_BITS-1:0] grp_bytes,
  input  logic [NB_W-1:0]                     grp_nbytes,
  input  logic [NBITS_W-1:0]                  grp_nbits,
  input  logic [WORD_W-1:0]                   grp_total,
  output logic                                grp_free,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output rsp_t                                rsp
);

  localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  logic                                valid;
  logic [IDX_W-1:0]                    idx;
  logic [IDX_W-1:0]                    last_idx;
  logic                                flush;
  logic [MAX_BYTES-1:0][BYTE_BITS-1:0] bytes;
  logic [NBITS_W-1:0]                  nbits;
  logic [WORD_W-1:0]                   total;
  logic                                at_last;

  always_comb begin
    at_last  = (idx == last_idx);
    grp_free = !valid || (!rsp_stall && at_last);

    rsp_valid        = valid;
    rsp.packed_byte  = bytes[idx];
    rsp.bits_in_byte = flush ? nbits : NBITS_W'(BYTE_BITS);
    rsp.total_bits   = flush ? total : '0;
    rsp.last         = at_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (grp_ctl.load) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (valid && !rsp_stall) begin
      if (at_last) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_ctl.load) begin
      bytes    <= grp_bytes;
      last_idx <= IDX_W'(grp_nbytes - 1'b1);
      flush    <= grp_ctl.flush;
      nbits    <= grp_nbits;
      total    <= grp_total;
    end
  end

endmodule

`default_nettype wire

>>> src/huffman_code_bit_packer_top.sv
`default_nettype none

// Table-driven variable-length encoder with an MSB-first byte packer. A load
// request (mode 0) writes one symbol's code word and length into a 256-entry
// code table; the length saturates at min(MAX_CODE_LEN, 32) and word bits
// above it are dropped. Load produces no response. An encode request (mode 1)
// looks the symbol up and appends its code to the pending bits; every byte
// that completes comes out as one response (bits_in_byte 8, total_bits 0),
// up to four per request, last set on the final one. A zero-length code adds
// nothing. A flush request (mode 2) always gives exactly one response: the
// 0..7 pending bits left-aligned and zero-padded, their count, and the 32-bit
// wrapping total of code bits since the previous flush; then pending bits and
// total clear. Mode 3 is dropped. Encoding a symbol never loaded gives
// undefined bytes. Timing: a request goes through the table read register,
// the packer and the output register on the way to its first response. One
// request is accepted per cycle while each makes at most one response and
// rsp_stall stays low; a request making more than one response holds the
// output register until its last is taken, and the single output byte per
// cycle limits throughput. The table needs no clearing after reset.
module huffman_code_bit_packer_top import hcbp_pkg::*; #(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int CODE_W    = (MAX_CODE_LEN > WORD_W) ? WORD_W : MAX_CODE_LEN;
  localparam int LEN_W     = $clog2(CODE_W + 1);
  localparam int ACC_W     = CODE_W + PEND_W;
  localparam int MAX_BYTES = ACC_W / BYTE_BITS;
  localparam int NB_W      = $clog2(MAX_BYTES + 1);

  logic                                take;
  logic [CODE_W-1:0]                   rd_word;
  logic [LEN_W-1:0]                    rd_len;
  logic                                grp_free;
  grp_ctl_t                            grp_ctl;
  logic [MAX_BYTES-1:0][BYTE_BITS-1:0] grp_bytes;
  logic [NB_W-1:0]                     grp_nbytes;
  logic [NBITS_W-1:0]                  grp_nbits;
  logic [WORD_W-1:0]                   grp_total;

  assign take = req_valid && !req_stall;

  // code table: load writes, every accepted request reads its entry
  hcbp_code_table #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_table (
    .clk     (clk),
    .take    (take),
    .req     (req),
    .rd_word (rd_word),
    .rd_len  (rd_len)
  );

  // packer: holds pending bits and bit total, forms a group of bytes
  hcbp_packer #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_packer (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .req_mode   (req.mode),
    .rd_word    (rd_word),
    .rd_len     (rd_len),
    .grp_free   (grp_free),
    .stall      (req_stall),
    .grp_ctl    (grp_ctl),
    .grp_bytes  (grp_bytes),
    .grp_nbytes (grp_nbytes),
    .grp_nbits  (grp_nbits),
    .grp_total  (grp_total)
  );

  // output register: hands the group out one byte per response
  hcbp_out_stage #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_out (
    .clk        (clk),
    .rst        (rst),
    .grp_ctl    (grp_ctl),
    .grp_bytes  (grp_bytes),
    .grp_nbytes (grp_nbytes),
    .grp_nbits  (grp_nbits),
    .grp_total  (grp_total),
    .grp_free   (grp_free),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

endmodule

`default_nettype wire

>>> src/hcbp_checker.sv
`default_nettype none

module hcbp_checker import hcbp_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // pipeline empties on reset; no stall and no response right after it
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !req_stall && !rsp_valid ##1 !rsp_valid)
    else $error("response or stall right after reset");

  // a partial byte only ever comes from a flush, which is always last
  a_partial_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.bits_in_byte != NBITS_W'(BYTE_BITS)) |-> rsp.last &&
      (rsp.bits_in_byte < NBITS_W'(BYTE_BITS)))
    else $error("partial byte not on a final flush response");

  // empty flush carries a zero byte
  a_empty_flush: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.bits_in_byte == '0) |-> (rsp.packed_byte == '0))
    else $error("empty flush with nonzero byte");

endmodule

bind huffman_code_bit_packer_top hcbp_checker u_hcbp_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps

// Testbench for the Huffman code bit packer.
//
// A queue of requests is built at time zero: a short directed list (empty
// flush, ignored mode, zero-length code, saturating and masked loads,
// encodes that give zero to four bytes, flushes of 0, 3 and 7 pending bits),
// then ~225 random requests. Most random requests encode a symbol that
// has already been loaded. Loads and flushes are mixed in, with a few
// mode 3 requests as noise.
//
// The driver offers requests from that queue. When a request is accepted,
// pack_request runs the packer's behavior on a private copy of the code
// table and the bit accumulator. It appends the bytes that request must
// produce to due_bytes. The monitor pops one entry per accepted response
// and compares it field by field.
//
// Both sides idle in random bursts. Once, the response side holds stall
// for a long stretch while the driver keeps offering requests, so the
// block backs up into req_stall. The tail of the run has no idling.
module tb import hcbp_pkg::*;;

  localparam int CODE_LIMIT = (MAX_CODE_LEN_DEF > WORD_W) ? WORD_W : MAX_CODE_LEN_DEF;
  localparam int RAND_REQS  = 225;
  localparam int CALM_TAIL  = 40;   // last requests sent with no idling
  localparam int HOLD_AT    = 60;   // accepted requests before the long stall
  localparam int HOLD_LEN   = 80;   // cycles of forced response stall
  localparam int DRAIN      = 16;   // quiet cycles after the last response

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  logic hold_rsp  = 1'b0;   // long response stall, driven by its own process
  logic calm      = 1'b0;   // set once only the tail of the stimulus is left

  huffman_code_bit_packer_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #2 clk = ~clk;

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------
  // Packer model: private code table, pending bits and running bit total.
  // ---------------------------------------------------------------------
  logic [WORD_W-1:0]   tbl_word [TABLE_DEPTH];
  logic [LEN_IN_W-1:0] tbl_len  [TABLE_DEPTH];
  logic [PEND_W-1:0]   acc_bits = '0;
  logic [PCNT_W-1:0]   acc_cnt  = '0;
  logic [WORD_W-1:0]   bit_sum  = '0;

  rsp_t due_bytes [$];      // responses owed by accepted requests, oldest first

  int n_load, n_encode, n_flush, n_ignored, n_four;
  int n_accepted, n_planned, n_checked, n_errors;

  function automatic void pack_request(req_t r);
    int          len;
    int          cnt;
    int          nb;
    logic [63:0] acc;
    rsp_t        o;
    case (r.mode)
      MODE_LOAD: begin
        // Length saturates at the code limit; word bits above it are dropped.
        len = (int'(r.code_length) > CODE_LIMIT) ? CODE_LIMIT : int'(r.code_length);
        tbl_len[r.symbol]  = LEN_IN_W'(len);
        tbl_word[r.symbol] = WORD_W'(64'(r.code_word) & ((64'd1 << len) - 64'd1));
        n_load++;
      end
      MODE_ENCODE: begin
        n_encode++;
        if (tbl_len[r.symbol] != '0) begin
          acc     = (64'(acc_bits) << tbl_len[r.symbol]) | 64'(tbl_word[r.symbol]);
          cnt     = int'(acc_cnt) + int'(tbl_len[r.symbol]);
          bit_sum = bit_sum + WORD_W'(tbl_len[r.symbol]);
          nb      = cnt / BYTE_BITS;
          for (int i = 0; i < nb; i++) begin
            o.packed_byte  = BYTE_BITS'(acc >> (cnt - BYTE_BITS * (i + 1)));
            o.bits_in_byte = NBITS_W'(BYTE_BITS);
            o.total_bits   = '0;
            o.last         = (i == nb - 1);
            due_bytes      = {due_bytes, o};
          end
          if (nb == 4) n_four++;
          cnt      = cnt % BYTE_BITS;
          acc_cnt  = PCNT_W'(cnt);
          acc_bits = PEND_W'(acc & ((64'd1 << cnt) - 64'd1));
        end
      end
      MODE_FLUSH: begin
        // Pending bits go out left-aligned and zero-padded, with the total.
        o.packed_byte  = BYTE_BITS'(16'(acc_bits) << (BYTE_BITS - int'(acc_cnt)));
        o.bits_in_byte = NBITS_W'(acc_cnt);
        o.total_bits   = bit_sum;
        o.last         = 1'b1;
        due_bytes      = {due_bytes, o};
        acc_bits = '0;
        acc_cnt  = '0;
        bit_sum  = '0;
        n_flush++;
      end
      default: n_ignored++;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------
  // Stimulus: directed list, then random requests.
  // ---------------------------------------------------------------------
  req_t pending_reqs [$];
  bit   sym_loaded [TABLE_DEPTH];
  int   known_syms [$];   // symbols that may be encoded

  function automatic void add_req(logic [1:0] m, int sym, logic [WORD_W-1:0] w, int len);
    req_t r;
    r.mode        = m;
    r.symbol      = SYM_W'(sym);
    r.code_word   = w;
    r.code_length = LEN_IN_W'(len);
    pending_reqs  = {pending_reqs, r};
    if (m == MODE_LOAD && !sym_loaded[sym]) begin
      sym_loaded[sym] = 1'b1;
      known_syms      = {known_syms, sym};
    end
  endfunction

  initial begin : stim
    int k;
    int len;
    int done;
    // directed part
    add_req(MODE_FLUSH,  8'h00, '0, 0);                      // nothing pending
    add_req(2'd3,        8'hFF, 32'hFFFF_FFFF, 63);          // unused mode
    add_req(MODE_LOAD,   8'h00, 32'hFFFF_FFFF, 0);           // zero-length code
    add_req(MODE_LOAD,   8'hFF, 32'hFFFF_FFFF, 32);          // longest code
    add_req(MODE_LOAD,   8'h01, 32'h5A5A_C3C3, 63);          // length saturates
    add_req(MODE_LOAD,   8'h02, 32'hFFFF_FFFE, 1);           // upper bits dropped
    add_req(MODE_LOAD,   8'h03, 32'hFFFF_FFFF, 3);
    add_req(MODE_LOAD,   8'h04, 32'h1234_56C3, 8);
    add_req(MODE_ENCODE, 8'h00, '0, 0);                      // appends nothing
    add_req(MODE_ENCODE, 8'h03, '0, 0);                      // no full byte yet
    add_req(MODE_ENCODE, 8'hFF, '0, 0);                      // four bytes out
    add_req(MODE_ENCODE, 8'h01, '0, 0);
    add_req(MODE_FLUSH,  8'h00, '0, 0);                      // 3 bits left over
    add_req(MODE_ENCODE, 8'h04, '0, 0);                      // exactly one byte
    add_req(MODE_FLUSH,  8'hFF, 32'hFFFF_FFFF, 63);          // empty, total 8
    add_req(MODE_ENCODE, 8'h03, '0, 0);
    add_req(MODE_ENCODE, 8'h03, '0, 0);
    add_req(MODE_ENCODE, 8'h02, '0, 0);                      // 7 bits pending
    add_req(MODE_ENCODE, 8'hFF, '0, 0);                      // 39 bits: 4 bytes + 7
    add_req(MODE_FLUSH,  8'h00, '0, 0);                      // full 7-bit tail
    add_req(2'd3,        8'h00, '0, 0);
    add_req(MODE_LOAD,   8'h03, 32'h0000_0007, 0);           // reload as zero length
    add_req(MODE_ENCODE, 8'h03, '0, 0);
    add_req(MODE_FLUSH,  8'h00, '0, 0);

    // random part; mode 3 noise does not count toward the total
    done = 0;
    while (done < RAND_REQS) begin
      k = $urandom_range(0, 99);
      if (k < 14) begin
        k = $urandom_range(0, 19);
        if (k == 0)       len = 0;
        else if (k <= 12) len = $urandom_range(1, 8);
        else if (k <= 16) len = $urandom_range(9, 20);
        else if (k <= 18) len = $urandom_range(21, 32);
        else              len = $urandom_range(33, 63);
        add_req(MODE_LOAD, $urandom_range(0, 255), $urandom, len);
        done++;
      end else if (k < 88) begin
        add_req(MODE_ENCODE, known_syms[$urandom_range(0, known_syms.size() - 1)],
                $urandom, $urandom_range(0, 63));
        done++;
      end else if (k < 96) begin
        add_req(MODE_FLUSH, $urandom_range(0, 255), $urandom, $urandom_range(0, 63));
        done++;
      end else begin
        add_req(2'd3, $urandom_range(0, 255), $urandom, $urandom_range(0, 63));
      end
    end
    add_req(MODE_FLUSH, 8'h00, '0, 0);   // check whatever is still pending
    n_planned = pending_reqs.size();
  end

  // ---------------------------------------------------------------------
  // Driver: offers requests, holds them while stalled, idles in bursts.
  // ---------------------------------------------------------------------
  int gap_left = 0;

  always @(posedge clk) begin : drv
    if (rst) begin
      req_valid <= 1'b0;
      calm      <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        pack_request(req);
        n_accepted++;
      end
      calm <= (pending_reqs.size() < CALM_TAIL);
      if (req_valid && req_stall) begin
        // stalled request stays put
      end else if (gap_left > 0) begin
        gap_left--;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        req_valid <= 1'b0;
      end else if (!hold_rsp && !calm && $urandom_range(0, 5) == 0) begin
        gap_left  = $urandom_range(0, 7);   // start a burst of idle cycles
        req_valid <= 1'b0;
      end else begin
        req_valid <= 1'b1;
        req       <= pending_reqs.pop_front();
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: stalls in bursts, checks each accepted response.
  // ---------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin : mon
    rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (due_bytes.size() == 0) begin
          report_mismatch($sformatf("response %0d with nothing owed (byte %02h)",
                                    n_checked, rsp.packed_byte));
        end else begin
          want = due_bytes.pop_front();
          if (rsp.packed_byte !== want.packed_byte)
            report_mismatch($sformatf("response %0d packed_byte %02h, want %02h",
                                      n_checked, rsp.packed_byte, want.packed_byte));
          if (rsp.bits_in_byte !== want.bits_in_byte)
            report_mismatch($sformatf("response %0d bits_in_byte %0d, want %0d",
                                      n_checked, rsp.bits_in_byte, want.bits_in_byte));
          if (rsp.total_bits !== want.total_bits)
            report_mismatch($sformatf("response %0d total_bits %0d, want %0d",
                                      n_checked, rsp.total_bits, want.total_bits));
          if (rsp.last !== want.last)
            report_mismatch($sformatf("response %0d last %b, want %b",
                                      n_checked, rsp.last, want.last));
        end
        n_checked++;
      end
      if (hold_rsp) begin
        rsp_stall <= 1'b1;
      end else if (calm) begin
        rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // Long response hold-off: the driver keeps offering, so the block fills up.
  initial begin : backpressure
    while (n_accepted < HOLD_AT) @(negedge clk);
    @(posedge clk);
    hold_rsp <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    hold_rsp <= 1'b0;
  end

  // ---------------------------------------------------------------------
  // End of run: all requests in, all owed responses out, then a short drain.
  // ---------------------------------------------------------------------
  initial begin : finish_up
    @(negedge clk);
    while (rst || n_planned == 0 || n_accepted < n_planned) @(negedge clk);
    while (due_bytes.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    $display("covered %0d requests: %0d loads, %0d encodes, %0d flushes, %0d mode-3",
             n_accepted, n_load, n_encode, n_flush, n_ignored);
    $display("checked %0d responses; %0d encodes produced four bytes; %0d errors",
             n_checked, n_four, n_errors);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("timeout: %0d of %0d requests accepted, %0d responses owed",
             n_accepted, n_planned, due_bytes.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
